// ----- sv/scma_pkg.sv -----
`timescale 1ns / 1ps

package scma_pkg;

   // List sizing
   localparam int MAX_ELEMS = 32;
   localparam int MAX_DIM   = 1024;
   localparam int ADDR_W    = $clog2(MAX_ELEMS);
   localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int VAL_W     = 32;

   // Configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_B = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B = 2'd3;

   // Request operations
   localparam logic [1:0] OP_LOAD_A = 2'd0;
   localparam logic [1:0] OP_LOAD_B = 2'd1;
   localparam logic [1:0] OP_MERGE  = 2'd2;

   // Response status codes
   localparam logic [1:0] STATUS_ELEM     = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]              op;
      logic [IDX_W-1:0]        elem_row;
      logic [IDX_W-1:0]        elem_col;
      logic signed [VAL_W-1:0] elem_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [VAL_W-1:0] out_value;
      logic [1:0]              status;
      logic                    last;
   } rsp_type;

   // One stored coordinate triple
   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] value;
   } elem_type;

   localparam int ELEM_W = $bits(elem_type);

   // Which list heads the merge step consumes
   typedef struct packed {
      logic take_a;
      logic take_b;
   } pick_type;

endpackage

// ----- sv/sparse_coo_matrix_add.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_type: op, elem_row, elem_col, elem_value
// rsp       out        rsp_valid/rsp_stall  rsp_type: out_row, out_col, out_value, status, last
// csr       in         csr_wr_en            csr_index, csr_wdata (rows/cols of A and B)
//
// A merge emits one merged element (up to 64) per cycle while the response is not stalled,
// a rate set by the single compare/add unit and the one read port of each list RAM.
// Reset is synchronous and clears the counts, the dimensions and the response valid flag.
// A stalled response holds the sequencer but not successful loads, which go on while a
// response waits.

module sparse_coo_matrix_add import scma_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MERGE = 2'd1;
   localparam logic [1:0] S_STAT  = 2'd2;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ELEMS);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [1:0]       stat_ff, stat_in;
   logic [DIM_W-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_payload_ff, rsp_payload_in;

   logic             slot_free;
   logic             we_a, we_b;
   elem_type         wr_elem;
   elem_type         head_a, head_b;
   logic             a_ok, b_ok;
   pick_type         pick;
   elem_type         merged;
   logic [CNT_W-1:0] i_step, j_step;
   logic             merge_done;
   logic             dim_mismatch;

   // Response register is free when empty or being taken this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign wr_elem.row   = req_payload.elem_row;
   assign wr_elem.col   = req_payload.elem_col;
   assign wr_elem.value = req_payload.elem_value;

   assign dim_mismatch = (rows_a_ff != rows_b_ff) || (cols_a_ff != cols_b_ff);

   // Read addresses follow the next head indices so the heads are ready each cycle
   scma_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ELEMS)) u_list_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (count_a_ff[ADDR_W-1:0]),
      .wr_data (wr_elem),
      .rd_addr (i_in[ADDR_W-1:0]),
      .rd_data (head_a)
   );

   scma_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ELEMS)) u_list_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (count_b_ff[ADDR_W-1:0]),
      .wr_data (wr_elem),
      .rd_addr (j_in[ADDR_W-1:0]),
      .rd_data (head_b)
   );

   assign a_ok = (i_ff < count_a_ff);
   assign b_ok = (j_ff < count_b_ff);

   scma_cmp u_cmp (
      .head_a (head_a),
      .head_b (head_b),
      .a_ok   (a_ok),
      .b_ok   (b_ok),
      .pick   (pick),
      .merged (merged)
   );

   assign i_step     = i_ff + {{(CNT_W-1){1'b0}}, pick.take_a};
   assign j_step     = j_ff + {{(CNT_W-1){1'b0}}, pick.take_b};
   assign merge_done = (i_step >= count_a_ff) && (j_step >= count_b_ff);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      stat_in    = stat_ff;
      we_a       = 1'b0;
      we_b       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.op)
                  OP_LOAD_A: begin
                     if (count_a_ff < CNT_FULL) begin
                        we_a       = 1'b1;
                        count_a_in = count_a_ff + CNT_ONE;
                     end else begin
                        stat_in  = STATUS_FULL;
                        state_in = S_STAT;
                     end
                  end
                  OP_LOAD_B: begin
                     if (count_b_ff < CNT_FULL) begin
                        we_b       = 1'b1;
                        count_b_in = count_b_ff + CNT_ONE;
                     end else begin
                        stat_in  = STATUS_FULL;
                        state_in = S_STAT;
                     end
                  end
                  OP_MERGE: begin
                     i_in = '0;
                     j_in = '0;
                     priority if (dim_mismatch) begin
                        stat_in    = STATUS_MISMATCH;
                        state_in   = S_STAT;
                        count_a_in = '0;
                        count_b_in = '0;
                     end else if ((count_a_ff == '0) && (count_b_ff == '0)) begin
                        stat_in  = STATUS_EMPTY;
                        state_in = S_STAT;
                     end else begin
                        state_in = S_MERGE;
                     end
                  end
                  default: begin
                     // unused op: drop silently
                  end
               endcase
            end
         end
         S_MERGE: begin
            if (slot_free) begin
               i_in = i_step;
               j_in = j_step;
               if (merge_done) begin
                  state_in   = S_IDLE;
                  count_a_in = '0;
                  count_b_in = '0;
               end
            end
         end
         S_STAT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register: hold while stalled, otherwise refill from the sequencer
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (slot_free) begin
         rsp_valid_in = 1'b0;
         priority if (state_ff == S_MERGE) begin
            rsp_valid_in             = 1'b1;
            rsp_payload_in.out_row   = merged.row;
            rsp_payload_in.out_col   = merged.col;
            rsp_payload_in.out_value = merged.value;
            rsp_payload_in.status    = STATUS_ELEM;
            rsp_payload_in.last      = merge_done;
         end else if (state_ff == S_STAT) begin
            rsp_valid_in             = 1'b1;
            rsp_payload_in.out_row   = '0;
            rsp_payload_in.out_col   = '0;
            rsp_payload_in.out_value = '0;
            rsp_payload_in.status    = stat_ff;
            rsp_payload_in.last      = 1'b1;
         end else begin
            rsp_payload_in = rsp_payload_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff        <= stat_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Dimension registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= '0;
         cols_a_ff <= '0;
         rows_b_ff <= '0;
         cols_b_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_A: rows_a_ff <= csr_wdata;
            CSR_COLS_A: cols_a_ff <= csr_wdata;
            CSR_ROWS_B: rows_b_ff <= csr_wdata;
            CSR_COLS_B: cols_b_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A list never grows past its capacity
   assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= CNT_FULL) && (count_b_ff <= CNT_FULL))
      else $error("list count beyond capacity");

   // While merging, at least one list still has a head left
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> (a_ok || b_ok))
      else $error("merge running with both lists exhausted");

   // Any status other than an element closes the request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_payload_ff.status != STATUS_ELEM)) |-> rsp_payload_ff.last)
      else $error("status response without last");

   // A stalled response freezes the merge walk
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MERGE) && rsp_valid_ff && rsp_stall) |=>
         ($stable(i_ff) && $stable(j_ff)))
      else $error("merge advanced under stall");

endmodule

// ----- sv/scma_ram.sv -----
`timescale 1ns / 1ps

module scma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/scma_cmp.sv -----
`timescale 1ns / 1ps

module scma_cmp import scma_pkg::*; (
   input  elem_type head_a,
   input  elem_type head_b,
   input  logic     a_ok,
   input  logic     b_ok,
   output pick_type pick,
   output elem_type merged
);

   logic a_first;
   logic b_first;

   // Row-major order: row first, then column
   assign a_first = (head_a.row < head_b.row) ||
                    ((head_a.row == head_b.row) && (head_a.col < head_b.col));
   assign b_first = (head_a.row > head_b.row) || (head_a.col > head_b.col);

   always_comb begin
      pick = '0;
      priority if (!a_ok) begin
         pick.take_b = 1'b1;
      end else if (!b_ok) begin
         pick.take_a = 1'b1;
      end else if (a_first) begin
         pick.take_a = 1'b1;
      end else if (b_first) begin
         pick.take_b = 1'b1;
      end else begin
         pick.take_a = 1'b1;
         pick.take_b = 1'b1;
      end
   end

   always_comb begin
      priority if (pick.take_a && pick.take_b) begin
         merged       = head_a;
         merged.value = head_a.value + head_b.value;
      end else if (pick.take_a) begin
         merged = head_a;
      end else begin
         merged = head_b;
      end
   end

endmodule
